// ===== hdl/trt_pkg.sv =====
// Package for the timestamp rebase tracker.
// Holds the shared ALU request type, the result beat struct and fixed widths.
// No dependencies.
package trt_pkg;

    // Fixed field and state widths
    localparam int DTS_W  = 33;   // input timestamps and 33-bit outputs
    localparam int CNT_W  = 16;   // frame count per segment
    localparam int ACC_W  = 64;   // running 64-bit state
    localparam int FT_W   = 32;   // frame total / divisor width

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        alu_op_t          op;
    } alu_req_t;

    // One result beat
    typedef struct packed {
        logic [DTS_W-1:0]        duration;
        logic signed [ACC_W-1:0] correction;
        logic [DTS_W-1:0]        first_dts;
    } trt_res_t;

endpackage

// ===== hdl/trt_alu.sv =====
// Shared 64-bit add/subtract unit with carry out.
// Depends on trt_pkg. Carry out on a subtract is high when a >= b.
module trt_alu (
    input  trt_pkg::alu_req_t    req,
    output logic [trt_pkg::ACC_W:0] sum
);
    import trt_pkg::*;

    logic [ACC_W-1:0] b_op;
    logic             cin;

    // Subtract as a + ~b + 1
    assign b_op = (req.op == ALU_SUB) ? ~req.b : req.b;
    assign cin  = (req.op == ALU_SUB);
    assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{ACC_W{1'b0}}, cin};

endmodule

// ===== hdl/trt_core.sv =====
// Sequencer and tracking state of the timestamp rebase tracker.
// Depends on trt_pkg and trt_alu. Every tracking add, subtract and division
// step uses the single trt_alu; division is restoring, one bit a cycle.
module trt_core #(
    parameter int TS_BITS = 33
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [trt_pkg::DTS_W-1:0]   first_dts,
    input  logic [trt_pkg::DTS_W-1:0]   last_dts,
    input  logic [trt_pkg::CNT_W-1:0]   num_frames,
    input  logic                        univ_flag,
    input  logic [trt_pkg::DTS_W-1:0]   threshold,
    output logic                        res_valid,
    input  logic                        res_ready,
    output trt_pkg::trt_res_t           res
);
    import trt_pkg::*;

    localparam int DIV_CW = $clog2(ACC_W);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(ACC_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORR,
        ST_GAP_A,
        ST_GAP_B,
        ST_REBASE,
        ST_CLAST,
        ST_CFIRST,
        ST_DELTA,
        ST_DTADD,
        ST_FTADD,
        ST_DIV,
        ST_EXP,
        ST_DUR,
        ST_DONE
    } state_t;

    state_t            state_reg;
    // captured item
    logic [DTS_W-1:0]  first_reg;
    logic [DTS_W-1:0]  last_reg;
    logic [CNT_W-1:0]  cm1_reg;
    // tracking state
    logic              exp_valid_reg;
    logic [ACC_W-1:0]  exp_reg;
    logic [ACC_W-1:0]  rc_reg;
    logic [ACC_W-1:0]  dt_reg;
    logic [FT_W-1:0]   ft_reg;
    // scratch
    logic [ACC_W-1:0]  t_reg;       // corrected first, later corrected last
    logic [ACC_W-1:0]  cfirst_reg;
    logic              gap_a_reg;
    logic [FT_W-1:0]   rem_reg;
    logic [ACC_W-1:0]  quo_reg;     // delta, then dividend / quotient
    logic [DIV_CW-1:0] cnt_reg;
    trt_res_t          res_reg;

    alu_req_t          alu_req;
    logic [ACC_W:0]    alu_sum;
    logic              alu_carry;
    logic              gap_over;
    logic [FT_W:0]     div_shift;

    trt_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign alu_carry = alu_sum[ACC_W];
    // Modular distance past the threshold
    assign gap_over  = ACC_W'(alu_sum[TS_BITS-1:0]) > ACC_W'(threshold);
    assign div_shift = {rem_reg, quo_reg[ACC_W-1]};

    // Operand selection for the shared ALU
    always_comb begin
        alu_req.a  = '0;
        alu_req.b  = '0;
        alu_req.op = ALU_ADD;
        unique case (state_reg)
            ST_CORR: begin
                alu_req.a = rc_reg;
                alu_req.b = ACC_W'(first_reg);
            end
            ST_GAP_A: begin
                alu_req.a  = exp_reg;
                alu_req.b  = t_reg;
                alu_req.op = ALU_SUB;
            end
            ST_GAP_B: begin
                alu_req.a  = t_reg;
                alu_req.b  = exp_reg;
                alu_req.op = ALU_SUB;
            end
            ST_REBASE: begin
                alu_req.a  = exp_reg;
                alu_req.b  = ACC_W'(first_reg);
                alu_req.op = ALU_SUB;
            end
            ST_CLAST: begin
                alu_req.a = ACC_W'(last_reg);
                alu_req.b = rc_reg;
            end
            ST_CFIRST: begin
                alu_req.a = ACC_W'(first_reg);
                alu_req.b = rc_reg;
            end
            ST_DELTA: begin
                alu_req.a  = ACC_W'(last_reg);
                alu_req.b  = ACC_W'(first_reg);
                alu_req.op = ALU_SUB;
            end
            ST_DTADD: begin
                alu_req.a = dt_reg;
                alu_req.b = quo_reg;
            end
            ST_FTADD: begin
                alu_req.a = ACC_W'(ft_reg);
                alu_req.b = ACC_W'(cm1_reg);
            end
            ST_DIV: begin
                alu_req.a  = ACC_W'(div_shift);
                alu_req.b  = ACC_W'(ft_reg);
                alu_req.op = ALU_SUB;
            end
            ST_EXP: begin
                alu_req.a = t_reg;
                alu_req.b = quo_reg;
            end
            ST_DUR: begin
                alu_req.a  = exp_reg;
                alu_req.b  = cfirst_reg;
                alu_req.op = ALU_SUB;
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    // Sequencer, tracking state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            exp_valid_reg <= 1'b0;
            exp_reg       <= '0;
            rc_reg        <= '0;
            dt_reg        <= '0;
            ft_reg        <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        first_reg <= first_dts;
                        last_reg  <= last_dts;
                        cm1_reg   <= num_frames - CNT_W'(1);
                        if (num_frames == '0) begin
                            // empty segment: zero result, state untouched
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else if (!univ_flag && exp_valid_reg) begin
                            state_reg <= ST_CORR;
                        end else begin
                            state_reg <= ST_CLAST;
                        end
                    end
                end
                ST_CORR: begin
                    t_reg     <= alu_sum[ACC_W-1:0];
                    state_reg <= ST_GAP_A;
                end
                ST_GAP_A: begin
                    gap_a_reg <= gap_over;
                    state_reg <= ST_GAP_B;
                end
                ST_GAP_B: begin
                    state_reg <= (gap_a_reg && gap_over) ? ST_REBASE : ST_CLAST;
                end
                ST_REBASE: begin
                    rc_reg    <= alu_sum[ACC_W-1:0];
                    state_reg <= ST_CLAST;
                end
                ST_CLAST: begin
                    t_reg     <= alu_sum[ACC_W-1:0];
                    state_reg <= ST_CFIRST;
                end
                ST_CFIRST: begin
                    cfirst_reg <= alu_sum[ACC_W-1:0];
                    state_reg  <= ST_DELTA;
                end
                ST_DELTA: begin
                    quo_reg   <= ACC_W'(alu_sum[TS_BITS-1:0]);
                    state_reg <= ST_DTADD;
                end
                ST_DTADD: begin
                    dt_reg    <= alu_sum[ACC_W-1:0];
                    state_reg <= ST_FTADD;
                end
                ST_FTADD: begin
                    ft_reg <= alu_sum[FT_W-1:0];
                    if (alu_sum[FT_W-1:0] == '0) begin
                        // no mean duration to add
                        quo_reg   <= '0;
                        state_reg <= ST_EXP;
                    end else begin
                        quo_reg   <= dt_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= alu_carry ? alu_sum[FT_W-1:0] : div_shift[FT_W-1:0];
                    quo_reg <= {quo_reg[ACC_W-2:0], alu_carry};
                    cnt_reg <= cnt_reg + DIV_CW'(1);
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    exp_reg       <= alu_sum[ACC_W-1:0];
                    exp_valid_reg <= 1'b1;
                    state_reg     <= ST_DUR;
                end
                ST_DUR: begin
                    res_reg.duration   <= DTS_W'(alu_sum[TS_BITS-1:0]);
                    res_reg.correction <= rc_reg;
                    res_reg.first_dts  <= first_reg;
                    state_reg          <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // No beat is taken while reset is held
    assign in_ready  = aresetn && (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

// ===== hdl/timestamp_rebase_tracker_unit.sv =====
// Top level of the timestamp rebase tracker: threshold register, output
// register and the sequencer core. Depends on trt_pkg and trt_core.
//
// Usage: one input beat per media segment on s_* (first/last DTS, frame
// count, universal-timestamp flag); one result beat per input on m_*
// (duration, signed correction to apply, uncorrected first DTS).
// The threshold is written through cfg_valid/cfg_ready/cfg_rebase_threshold,
// which is ready whenever reset is released; write it only while no segment
// is in flight.
// A segment with frame count zero goes straight to its result. Otherwise
// the core steps the shared 64-bit adder through 7 to 11 operations plus
// 64 restoring-division steps (skipped when the frame total is zero).
// One segment at a time: s_ready is high only while the core is idle, so
// a new segment is taken only once the core is done with the last one.
// A finished result sits in the output register; the core may accept the
// next segment meanwhile, and holds its next result until the output
// register is free. Reset (aresetn low, synchronous) clears the tracking
// state, drops m_valid, s_ready and cfg_ready and sets the threshold to 900000.
module timestamp_rebase_tracker_unit #(
    parameter int TS_BITS = 33
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [trt_pkg::DTS_W-1:0]          cfg_rebase_threshold,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [trt_pkg::DTS_W-1:0]          s_first_dts,
    input  logic [trt_pkg::DTS_W-1:0]          s_last_dts,
    input  logic [trt_pkg::CNT_W-1:0]          s_num_frames,
    input  logic                               s_univ_flag,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [trt_pkg::DTS_W-1:0]          m_duration,
    output logic signed [trt_pkg::ACC_W-1:0]   m_applied_correction,
    output logic [trt_pkg::DTS_W-1:0]          m_original_first_dts
);
    import trt_pkg::*;

    localparam logic [DTS_W-1:0] THR_RESET = DTS_W'(900000);

    logic [DTS_W-1:0] thr_reg;
    logic             m_valid_reg;
    trt_res_t         out_reg;
    logic             res_valid;
    logic             res_ready;
    trt_res_t         res;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_rebase_threshold;
        end
    end

    assign cfg_ready = aresetn;

    trt_core #(
        .TS_BITS (TS_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .first_dts  (s_first_dts),
        .last_dts   (s_last_dts),
        .num_frames (s_num_frames),
        .univ_flag  (s_univ_flag),
        .threshold  (thr_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: free when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
            if (res_valid) begin
                out_reg <= res;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_duration           = out_reg.duration;
    assign m_applied_correction = out_reg.correction;
    assign m_original_first_dts = out_reg.first_dts;

endmodule

// ===== hdl/trt_checker.sv =====
// Port-level checks for timestamp_rebase_tracker_unit, attached by bind.
// Depends on trt_pkg for field widths.
module trt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [trt_pkg::DTS_W-1:0]        m_duration,
    input logic signed [trt_pkg::ACC_W-1:0] m_applied_correction,
    input logic [trt_pkg::DTS_W-1:0]        m_original_first_dts
);
    import trt_pkg::*;

    // Core is busy right after taking a segment
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high the cycle after an input beat");

    // A result is handed over as the core returns to idle
    a_idle_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded while core still busy");

    // No result can appear in the cycle after an input beat into an empty output
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after input beat");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duration)
            && $stable(m_applied_correction) && $stable(m_original_first_dts))
        else $error("stalled result beat changed");

endmodule

bind timestamp_rebase_tracker_unit trt_checker u_trt_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_duration           (m_duration),
    .m_applied_correction (m_applied_correction),
    .m_original_first_dts (m_original_first_dts)
);
